### rtl/inpv_pkg.sv
// types and codes shared by the ipc name and path validator
package inpv_pkg;

   typedef enum logic [1:0] {
      KIND_WELL_KNOWN = 2'd0,
      KIND_UNIQUE     = 2'd1,
      KIND_INTERFACE  = 2'd2,
      KIND_PATH       = 2'd3
   } kind_type;

   typedef enum logic [1:0] {
      CLS_OTHER = 2'd0,
      CLS_COLON = 2'd1,
      CLS_DOT   = 2'd2,
      CLS_SLASH = 2'd3
   } char_class_type;

   typedef enum logic [3:0] {
      ERR_OK            = 4'd0,
      ERR_EMPTY         = 4'd1,
      ERR_COLON_START   = 4'd2,
      ERR_MISSING_COLON = 4'd3,
      ERR_DOT_START     = 4'd4,
      ERR_NO_DOT        = 4'd5,
      ERR_TOO_LONG      = 4'd6,
      ERR_NO_SLASH      = 4'd7,
      ERR_EMPTY_ELEMENT = 4'd8,
      ERR_BAD_CHAR      = 4'd9
   } err_type;

   localparam logic [7:0] CHAR_COLON = 8'h3a;
   localparam logic [7:0] CHAR_DOT   = 8'h2e;
   localparam logic [7:0] CHAR_SLASH = 8'h2f;
   localparam logic [7:0] CHAR_UNDER = 8'h5f;
   localparam logic [7:0] LEN_MAX    = 8'd255;

   typedef struct packed {
      logic [1:0] name_kind;
      logic [7:0] char_byte;
      logic       last_byte;
      logic       empty_string;
   } req_type;

   typedef struct packed {
      logic       valid_res;
      logic [3:0] error_code;
   } rsp_type;

   function automatic char_class_type classify(input logic [7:0] c);
      char_class_type cls;
      if (c == CHAR_COLON) begin
         cls = CLS_COLON;
      end else if (c == CHAR_DOT) begin
         cls = CLS_DOT;
      end else if (c == CHAR_SLASH) begin
         cls = CLS_SLASH;
      end else begin
         cls = CLS_OTHER;
      end
      return cls;
   endfunction

   function automatic logic path_char_ok(input logic [7:0] c);
      logic ok;
      ok = ((c >= 8'h41) && (c <= 8'h5a)) || ((c >= 8'h61) && (c <= 8'h7a)) ||
           ((c >= 8'h30) && (c <= 8'h39)) || (c == CHAR_UNDER) || (c == CHAR_SLASH);
      return ok;
   endfunction

endpackage

### rtl/ipc_name_and_path_validator_core.sv
// ipc name and path validator: per-byte flag tracking and verdict at the last byte
//
// Usage: strings arrive one byte per req beat (req_valid / req_stall, payload
// req_data). The kind of string is taken from name_kind on a string's first
// byte. A beat with empty_string set is a whole empty string on its own and
// drops any string in progress. One rsp beat (rsp_valid / rsp_stall, payload
// rsp_data) carries the verdict of each string: valid_res and error_code.
// Bytes that are not the last of a string give no rsp beat.
// Verdicts are registered: in the result register, or the skid entry if that is held.
// Throughput: one byte per cycle while req_stall is low, set by the single flag update per byte.
// A result register plus one skid entry part the two sides, so bytes keep
// flowing while one verdict waits; req_stall rises only when a second verdict
// is parked in the skid entry and stays up until the receiver drains it.
// Reset (synchronous, active high) clears all flags, empties the result and
// skid registers and leaves the block awaiting a first byte.
// NAME_LIMIT: names whose length reaches it are rejected as too long.
module ipc_name_and_path_validator_core #(
   parameter int NAME_LIMIT = 255
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  inpv_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output inpv_pkg::rsp_type rsp_data
);

   localparam logic [7:0] LIMIT = 8'(NAME_LIMIT);

   logic                     at_start_ff, at_start_in;
   inpv_pkg::kind_type       kind_ff, kind_in;
   logic [7:0]               len_ff, len_in;
   inpv_pkg::char_class_type fcls_ff, fcls_in;
   logic                     seen_dot_ff, seen_dot_in;
   logic                     prev_slash_ff, prev_slash_in;
   logic                     empty_el_ff, empty_el_in;
   logic                     bad_ff, bad_in;

   logic                     out_valid_ff, out_valid_in;
   inpv_pkg::rsp_type        out_ff, out_in;
   logic                     skid_valid_ff, skid_valid_in;
   inpv_pkg::rsp_type        skid_ff, skid_in;

   logic                     accept;
   logic                     produce;
   logic                     first;
   logic                     out_free;
   logic [7:0]               c;
   inpv_pkg::kind_type       kind_cur;
   inpv_pkg::char_class_type fcls_cur;
   logic                     seen_dot_cur;
   logic                     empty_el_cur;
   logic                     bad_cur;
   logic [7:0]               len_cur;
   inpv_pkg::err_type        err;
   inpv_pkg::rsp_type        new_rsp;

   assign accept    = req_valid && !req_stall;
   assign req_stall = skid_valid_ff;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;
   assign out_free  = !out_valid_ff || !rsp_stall;
   assign produce   = accept && (req_data.empty_string || req_data.last_byte);

   // flags including the current byte
   always_comb begin
      c            = req_data.char_byte;
      first        = at_start_ff;
      kind_cur     = first ? inpv_pkg::kind_type'(req_data.name_kind) : kind_ff;
      fcls_cur     = first ? inpv_pkg::classify(c) : fcls_ff;
      seen_dot_cur = (!first && seen_dot_ff) || (c == inpv_pkg::CHAR_DOT);
      empty_el_cur = (!first && empty_el_ff) ||
                     ((c == inpv_pkg::CHAR_SLASH) && !first &&
                      (prev_slash_ff || req_data.last_byte));
      bad_cur      = (!first && bad_ff) || !inpv_pkg::path_char_ok(c);
      if (first) begin
         len_cur = 8'd1;
      end else if (len_ff < inpv_pkg::LEN_MAX) begin
         len_cur = len_ff + 8'd1;
      end else begin
         len_cur = len_ff;
      end
   end

   // verdict in check order
   always_comb begin
      err = inpv_pkg::ERR_OK;
      if (req_data.empty_string) begin
         err = inpv_pkg::ERR_EMPTY;
      end else if (kind_cur == inpv_pkg::KIND_PATH) begin
         if (fcls_cur != inpv_pkg::CLS_SLASH) begin
            err = inpv_pkg::ERR_NO_SLASH;
         end else if (empty_el_cur) begin
            err = inpv_pkg::ERR_EMPTY_ELEMENT;
         end else if (bad_cur) begin
            err = inpv_pkg::ERR_BAD_CHAR;
         end
      end else if (kind_cur == inpv_pkg::KIND_WELL_KNOWN &&
                   fcls_cur == inpv_pkg::CLS_COLON) begin
         err = inpv_pkg::ERR_COLON_START;
      end else if (kind_cur == inpv_pkg::KIND_UNIQUE &&
                   fcls_cur != inpv_pkg::CLS_COLON) begin
         err = inpv_pkg::ERR_MISSING_COLON;
      end else if (kind_cur != inpv_pkg::KIND_INTERFACE &&
                   fcls_cur == inpv_pkg::CLS_DOT) begin
         err = inpv_pkg::ERR_DOT_START;
      end else if (!seen_dot_cur) begin
         err = inpv_pkg::ERR_NO_DOT;
      end else if (len_cur >= LIMIT) begin
         err = inpv_pkg::ERR_TOO_LONG;
      end
      new_rsp.valid_res  = (err == inpv_pkg::ERR_OK);
      new_rsp.error_code = err;
   end

   // string state next values
   always_comb begin
      at_start_in   = at_start_ff;
      kind_in       = kind_ff;
      len_in        = len_ff;
      fcls_in       = fcls_ff;
      seen_dot_in   = seen_dot_ff;
      prev_slash_in = prev_slash_ff;
      empty_el_in   = empty_el_ff;
      bad_in        = bad_ff;
      if (accept) begin
         if (req_data.empty_string || req_data.last_byte) begin
            at_start_in   = 1'b1;
            kind_in       = inpv_pkg::KIND_WELL_KNOWN;
            len_in        = 8'd0;
            fcls_in       = inpv_pkg::CLS_OTHER;
            seen_dot_in   = 1'b0;
            prev_slash_in = 1'b0;
            empty_el_in   = 1'b0;
            bad_in        = 1'b0;
         end else begin
            at_start_in   = 1'b0;
            kind_in       = kind_cur;
            len_in        = len_cur;
            fcls_in       = fcls_cur;
            seen_dot_in   = seen_dot_cur;
            prev_slash_in = (c == inpv_pkg::CHAR_SLASH);
            empty_el_in   = empty_el_cur;
            bad_in        = bad_cur;
         end
      end
   end

   // result register and skid entry
   always_comb begin
      out_valid_in  = out_valid_ff;
      out_in        = out_ff;
      skid_valid_in = skid_valid_ff;
      skid_in       = skid_ff;
      if (out_free) begin
         if (skid_valid_ff) begin
            out_valid_in  = 1'b1;
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end else begin
            out_valid_in = produce;
            out_in       = new_rsp;
         end
      end else if (produce) begin
         skid_valid_in = 1'b1;
         skid_in       = new_rsp;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         at_start_ff   <= 1'b1;
         kind_ff       <= inpv_pkg::KIND_WELL_KNOWN;
         len_ff        <= 8'd0;
         fcls_ff       <= inpv_pkg::CLS_OTHER;
         seen_dot_ff   <= 1'b0;
         prev_slash_ff <= 1'b0;
         empty_el_ff   <= 1'b0;
         bad_ff        <= 1'b0;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         at_start_ff   <= at_start_in;
         kind_ff       <= kind_in;
         len_ff        <= len_in;
         fcls_ff       <= fcls_in;
         seen_dot_ff   <= seen_dot_in;
         prev_slash_ff <= prev_slash_in;
         empty_el_ff   <= empty_el_in;
         bad_ff        <= bad_in;
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   a_skid_needs_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry held while result register empty");

   a_verdict_flag: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> (out_ff.valid_res == (out_ff.error_code == inpv_pkg::ERR_OK)))
      else $error("valid_res disagrees with error_code");

   a_end_rearms: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_data.empty_string || req_data.last_byte)) |=> at_start_ff)
      else $error("not awaiting a first byte after string end");

   a_end_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      (accept && (req_data.empty_string || req_data.last_byte)) |=> out_valid_ff)
      else $error("string end produced no result");

   a_mid_clears_start: assert property (@(posedge clock) disable iff (reset)
      (accept && !req_data.empty_string && !req_data.last_byte) |=> !at_start_ff)
      else $error("start flag set in the middle of a string");

endmodule

### dv/ipc_name_and_path_validator_core_test.sv
// self-checking testbench for the ipc name and path validator core
module ipc_name_and_path_validator_core_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int PERIOD      = 4;
   localparam int NAME_LIMIT  = 255;
   localparam int ITEM_COUNT  = 400;
   localparam int CYCLE_LIMIT = 200000;

   typedef logic [7:0] byte_list_type[$];

   logic              clock     = 1'b0;
   logic              reset     = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   inpv_pkg::req_type req_data  = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   inpv_pkg::rsp_type rsp_data;

   bit req_calm = 1'b0;
   bit rsp_calm = 1'b0;
   int unsigned accepted_items = 0;
   int unsigned cycle_count = 0;

   always #(PERIOD / 2) clock = ~clock;

   ipc_name_and_path_validator_core #(
      .NAME_LIMIT(NAME_LIMIT)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // tracks the string in flight and the verdicts still owed by the block
   class verdict_board;
      bit                       awaiting_first;
      inpv_pkg::kind_type       kind_q;
      logic [7:0]               byte_count;
      inpv_pkg::char_class_type lead_class;
      bit                       dot_seen;
      bit                       last_was_slash;
      bit                       empty_elem;
      bit                       bad_char;
      inpv_pkg::rsp_type        verdicts_due[$];
      int unsigned              mismatches;

      function new();
         clear_string();
         mismatches = 0;
      endfunction

      function void clear_string();
         awaiting_first = 1'b1;
         kind_q         = inpv_pkg::KIND_WELL_KNOWN;
         byte_count     = '0;
         lead_class     = inpv_pkg::CLS_OTHER;
         dot_seen       = 1'b0;
         last_was_slash = 1'b0;
         empty_elem     = 1'b0;
         bad_char       = 1'b0;
      endfunction

      function inpv_pkg::char_class_type class_of(logic [7:0] c);
         case (c)
            inpv_pkg::CHAR_COLON: return inpv_pkg::CLS_COLON;
            inpv_pkg::CHAR_DOT:   return inpv_pkg::CLS_DOT;
            inpv_pkg::CHAR_SLASH: return inpv_pkg::CLS_SLASH;
            default:              return inpv_pkg::CLS_OTHER;
         endcase
      endfunction

      function bit path_byte_ok(logic [7:0] c);
         return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z") ||
                (c >= "0" && c <= "9") || c == inpv_pkg::CHAR_UNDER ||
                c == inpv_pkg::CHAR_SLASH;
      endfunction

      function inpv_pkg::err_type judge();
         if (kind_q == inpv_pkg::KIND_PATH) begin
            if (lead_class != inpv_pkg::CLS_SLASH) return inpv_pkg::ERR_NO_SLASH;
            if (empty_elem) return inpv_pkg::ERR_EMPTY_ELEMENT;
            if (bad_char) return inpv_pkg::ERR_BAD_CHAR;
            return inpv_pkg::ERR_OK;
         end
         if (kind_q == inpv_pkg::KIND_WELL_KNOWN && lead_class == inpv_pkg::CLS_COLON)
            return inpv_pkg::ERR_COLON_START;
         if (kind_q == inpv_pkg::KIND_UNIQUE && lead_class != inpv_pkg::CLS_COLON)
            return inpv_pkg::ERR_MISSING_COLON;
         if (kind_q != inpv_pkg::KIND_INTERFACE && lead_class == inpv_pkg::CLS_DOT)
            return inpv_pkg::ERR_DOT_START;
         if (!dot_seen) return inpv_pkg::ERR_NO_DOT;
         if (int'(byte_count) >= NAME_LIMIT) return inpv_pkg::ERR_TOO_LONG;
         return inpv_pkg::ERR_OK;
      endfunction

      function void owe(inpv_pkg::err_type e);
         inpv_pkg::rsp_type v;
         v.valid_res  = (e == inpv_pkg::ERR_OK);
         v.error_code = e;
         verdicts_due.push_back(v);
      endfunction

      function void note_request(inpv_pkg::req_type item);
         bit first;
         if (item.empty_string) begin
            // drops any string in progress
            clear_string();
            owe(inpv_pkg::ERR_EMPTY);
            return;
         end
         first = awaiting_first;
         if (first) begin
            clear_string();
            kind_q     = inpv_pkg::kind_type'(item.name_kind);
            lead_class = class_of(item.char_byte);
         end
         if (item.char_byte == inpv_pkg::CHAR_DOT) dot_seen = 1'b1;
         if (item.char_byte == inpv_pkg::CHAR_SLASH && !first &&
             (last_was_slash || item.last_byte))
            empty_elem = 1'b1;
         if (!path_byte_ok(item.char_byte)) bad_char = 1'b1;
         last_was_slash = (item.char_byte == inpv_pkg::CHAR_SLASH);
         if (byte_count != inpv_pkg::LEN_MAX) byte_count = byte_count + 8'd1;
         awaiting_first = 1'b0;
         if (item.last_byte) begin
            owe(judge());
            clear_string();
         end
      endfunction

      function void check_response(inpv_pkg::rsp_type got);
         inpv_pkg::rsp_type want;
         if (verdicts_due.size() == 0) begin
            $error("verdict beat with none due: valid_res %0d error_code %0d",
                   got.valid_res, got.error_code);
            mismatches++;
            return;
         end
         want = verdicts_due.pop_front();
         if (got.valid_res !== want.valid_res) begin
            $error("valid_res: expected %0d, got %0d", want.valid_res, got.valid_res);
            mismatches++;
         end
         if (got.error_code !== want.error_code) begin
            $error("error_code: expected %0d, got %0d", want.error_code, got.error_code);
            mismatches++;
         end
      endfunction

      function int pending();
         return verdicts_due.size();
      endfunction
   endclass

   verdict_board board = new();

   function automatic inpv_pkg::req_type make_beat(logic [1:0] kind, logic [7:0] c,
                                                   logic last, logic empty);
      inpv_pkg::req_type item;
      item.name_kind    = kind;
      item.char_byte    = c;
      item.last_byte    = last;
      item.empty_string = empty;
      return item;
   endfunction

   function automatic logic [7:0] word_char();
      int pick;
      pick = $urandom_range(0, 62);
      if (pick < 10) return "0" + 8'(pick);
      if (pick < 36) return "A" + 8'(pick - 10);
      if (pick < 62) return "a" + 8'(pick - 36);
      return inpv_pkg::CHAR_UNDER;
   endfunction

   function automatic logic [7:0] odd_char();
      case ($urandom_range(0, 4))
         0:       return inpv_pkg::CHAR_COLON;
         1:       return inpv_pkg::CHAR_DOT;
         2:       return inpv_pkg::CHAR_SLASH;
         3:       return "-";
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic byte_list_type random_name(input inpv_pkg::kind_type kind);
      byte_list_type text;
      int parts, width;
      if (kind == inpv_pkg::KIND_UNIQUE && $urandom_range(0, 4) != 0)
         text.push_back(inpv_pkg::CHAR_COLON);
      parts = $urandom_range(1, 4);
      for (int p = 0; p < parts; p++) begin
         if (p > 0) text.push_back(inpv_pkg::CHAR_DOT);
         width = $urandom_range(1, 4);
         for (int k = 0; k < width; k++) text.push_back(word_char());
      end
      if ($urandom_range(0, 3) == 0) text[$urandom_range(0, text.size() - 1)] = odd_char();
      return text;
   endfunction

   function automatic byte_list_type random_path();
      byte_list_type text;
      int parts, width;
      text.push_back(($urandom_range(0, 19) == 0) ? word_char() : inpv_pkg::CHAR_SLASH);
      // one in ten stays the root path
      if ($urandom_range(0, 9) != 0) begin
         parts = $urandom_range(1, 4);
         for (int p = 0; p < parts; p++) begin
            if (p > 0) text.push_back(inpv_pkg::CHAR_SLASH);
            width = $urandom_range(1, 5);
            for (int k = 0; k < width; k++) text.push_back(word_char());
         end
      end
      case ($urandom_range(0, 11))
         0:       text[$urandom_range(0, text.size() - 1)] = odd_char();
         1:       text.push_back(inpv_pkg::CHAR_SLASH);
         2:       text.insert($urandom_range(0, text.size()), inpv_pkg::CHAR_SLASH);
         default: ;
      endcase
      return text;
   endfunction

   task automatic send_beat(input inpv_pkg::req_type item);
      int gap;
      gap = req_calm ? 0 : $urandom_range(0, 4);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_stall);
      board.note_request(item);
      accepted_items++;
   endtask

   task automatic send_empty();
      send_beat(make_beat(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                          1'($urandom_range(0, 1)), 1'b1));
   endtask

   // name_kind on later bytes is random since the block must ignore it
   task automatic send_string(input inpv_pkg::kind_type kind, input byte_list_type text,
                              input bit may_drop);
      for (int i = 0; i < text.size(); i++) begin
         if (may_drop && i > 0 && $urandom_range(0, 59) == 0) begin
            send_empty();
            return;
         end
         send_beat(make_beat((i == 0) ? 2'(kind) : 2'($urandom_range(0, 3)), text[i],
                             i == text.size() - 1, 1'b0));
      end
   endtask

   task automatic send_text(input inpv_pkg::kind_type kind, input string s);
      byte_list_type text;
      for (int i = 0; i < s.len(); i++) text.push_back(s[i]);
      send_string(kind, text, 1'b0);
   endtask

   task automatic send_long(input inpv_pkg::kind_type kind, input logic [7:0] lead,
                            input int count);
      byte_list_type text;
      text.push_back(lead);
      if (kind != inpv_pkg::KIND_PATH) text.push_back(inpv_pkg::CHAR_DOT);
      while (text.size() < count) text.push_back(word_char());
      send_string(kind, text, 1'b0);
   endtask

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("*** FAILED ***");
      $finish;
   end

   // result side: random stall before each beat, sometimes long calm stretches
   initial begin
      int hold;
      wait (!reset);
      forever begin
         if ($urandom_range(0, 15) == 0) rsp_calm = ~rsp_calm;
         hold = rsp_calm ? 0 : $urandom_range(0, 4);
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (!rsp_valid);
         board.check_response(rsp_data);
      end
   end

   initial begin
      int pick;
      inpv_pkg::kind_type kind;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed corners
      send_beat(make_beat(inpv_pkg::KIND_PATH, 8'hff, 1'b0, 1'b1));
      send_beat(make_beat(inpv_pkg::KIND_WELL_KNOWN, 8'h00, 1'b1, 1'b1));
      send_text(inpv_pkg::KIND_PATH, "/");
      send_text(inpv_pkg::KIND_WELL_KNOWN, ":.");
      send_text(inpv_pkg::KIND_UNIQUE, "a.");
      send_text(inpv_pkg::KIND_UNIQUE, ":.");
      send_text(inpv_pkg::KIND_WELL_KNOWN, ".");
      send_text(inpv_pkg::KIND_INTERFACE, "x");
      send_text(inpv_pkg::KIND_INTERFACE, ":.");
      send_text(inpv_pkg::KIND_PATH, "a");
      send_text(inpv_pkg::KIND_PATH, "//");
      send_text(inpv_pkg::KIND_PATH, "/a/");
      send_string(inpv_pkg::KIND_PATH, '{inpv_pkg::CHAR_SLASH, 8'hff}, 1'b0);
      // empty string arriving mid-string drops it
      send_beat(make_beat(inpv_pkg::KIND_WELL_KNOWN, 8'h00, 1'b0, 1'b0));
      send_beat(make_beat(inpv_pkg::KIND_UNIQUE, 8'h80, 1'b1, 1'b1));

      // one byte past the limit, so the count saturates right at it
      send_long(inpv_pkg::KIND_WELL_KNOWN, "a", NAME_LIMIT + 1);

      while (accepted_items < ITEM_COUNT) begin
         if ($urandom_range(0, 7) == 0) req_calm = ~req_calm;
         pick = $urandom_range(0, 99);
         if (pick < 8) begin
            send_empty();
         end else if (pick < 55) begin
            kind = inpv_pkg::kind_type'($urandom_range(0, 2));
            send_string(kind, random_name(kind), 1'b1);
         end else begin
            send_string(inpv_pkg::KIND_PATH, random_path(), 1'b1);
         end
      end
      req_valid <= 1'b0;

      while (board.pending() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (board.mismatches == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
